// ===== hdl/alms_pkg.sv =====
// Shared types and constants of the adaptive LMS FIR filter.
// Holds field widths, register indexes, operation and mode codes.
// No dependencies.
`default_nettype none

package alms_pkg;

  // stream payload widths
  localparam int OP_W       = 2;
  localparam int SMP_W      = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_W      = 18;
  localparam int WGT_W      = 24;
  localparam int MSE_W      = 32;
  localparam int STEP_W     = 32;
  localparam int PEAK_W     = 17;
  localparam int OUT_DATA_W = 120;
  localparam int SUM_W      = 48;

  // output tdata field offsets
  localparam int OFS_ERR  = 18;
  localparam int OFS_MSE  = 36;
  localparam int OFS_CONV = 68;
  localparam int OFS_STEP = 69;
  localparam int OFS_PEAK = 101;

  // divider dividend width, large enough for the normalized update
  localparam int DIV_NW = 56;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EPS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 3'd4;

  // operation codes
  localparam logic [OP_W-1:0] OP_SAMPLE    = 2'd0;
  localparam logic [OP_W-1:0] OP_CLR_FILT  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLR_STATS = 2'd2;

  // adaptation modes
  localparam logic [1:0] MODE_LMS  = 2'd0;
  localparam logic [1:0] MODE_NLMS = 2'd1;
  localparam logic [1:0] MODE_SIGN = 2'd2;

  // limits
  localparam int OUT_MAX  = 131071;
  localparam int STEP_MAX = 131072;
  localparam int PEAK_MAX = 131071;

endpackage

`default_nettype wire

// ===== hdl/alms_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by the adaptive LMS FIR filter top level.
`default_nettype none

module alms_div #(
  parameter int NW = 56,
  parameter int DW = 40
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               done_o,
  output logic [NW-1:0]      quot_o
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem_q;
  logic [NW-1:0]    num_q;
  logic [DW-1:0]    den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DW:0]      shift_c;
  logic [DW:0]      diff_c;
  logic             fit_c;

  // trial subtract of the shifted remainder
  always_comb begin
    shift_c = {rem_q, num_q[NW-1]};
    diff_c  = shift_c - {1'b0, den_q};
    fit_c   = shift_c >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      num_q  <= '0;
      den_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(NW);
      rem_q  <= '0;
      num_q  <= dividend_i;
      den_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fit_c ? diff_c[DW-1:0] : shift_c[DW-1:0];
      num_q <= {num_q[NW-2:0], fit_c};
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

`default_nettype wire

// ===== hdl/adaptive_lms_fir_filter.sv =====
// Adaptive FIR filter (LMS, normalized LMS, sign-error LMS) with MSE tracking.
// One item at a time over n taps: taps and weights sit in memories that are read
// one tap per pass of the read, multiply and accumulate states; the shared serial
// divider, used per tap in normalized mode and for the mean squared error once the
// error window holds 2*n errors, gives one bit a cycle. Clear ops go straight to the result.
// Reset (async, active low) clears taps, weights (via valid bits) and statistics.
// Depends on alms_pkg and alms_div.
`default_nettype none

module adaptive_lms_fir_filter #(
  parameter int ORDER_MAX = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration writes
  input  wire logic                                cfg_we_i,
  input  wire logic [alms_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [alms_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // input stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // input_sample [15:0], desired_sample [31:16]
  input  wire logic [alms_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // op [1:0]
  input  wire logic [alms_pkg::OP_W-1:0]           s_axis_tuser,
  // result stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // filter_out [17:0], error_out [35:18], mean_sq_error [67:36],
  // is_converged [68], converge_step [100:69], peak_error [117:101], zero pad
  output logic [alms_pkg::OUT_DATA_W-1:0]          m_axis_tdata
);

  import alms_pkg::*;

  localparam int AW      = $clog2(ORDER_MAX);
  localparam int OW      = $clog2(ORDER_MAX + 1);
  localparam int ACC_W   = 40 + AW;
  localparam int EN_W    = 31 + AW;
  localparam int PW      = 34 + AW;
  localparam int CW      = $clog2(10 * ORDER_MAX + 2);
  localparam int ORD_RST = (ORDER_MAX < 32) ? ORDER_MAX : 32;
  localparam int DWW     = DIV_NW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_MAC_RD, S_MAC_MUL, S_MAC_ACC, S_Y, S_ERR, S_PREP,
    S_UPD_RD, S_UPD_MUL, S_UPD_DW, S_UPD_DIV, S_UPD_WR, S_STAT, S_MSE_DIV, S_FIN
  } state_e;

  state_e state_q;

  // configuration
  logic [1:0]    mode_q;
  logic [OW-1:0] order_q;
  logic [17:0]   mu_q;
  logic [31:0]   eps_q;
  logic [31:0]   thr_q;

  // memories and their valid bits
  logic signed [SMP_W-1:0] tap_mem [ORDER_MAX];
  logic signed [WGT_W-1:0] w_mem [ORDER_MAX];
  logic [ORDER_MAX-1:0]    tap_vld_q;
  logic [ORDER_MAX-1:0]    w_vld_q;
  logic signed [SMP_W-1:0] tap_rd_q;
  logic signed [WGT_W-1:0] w_rd_q;
  logic                    tap_rdv_q;
  logic                    w_rdv_q;
  logic signed [SMP_W-1:0] tap_x;
  logic signed [WGT_W-1:0] w_x;

  // datapath registers
  logic [AW-1:0]           wp_q;
  logic [AW-1:0]           idx_q;
  logic [AW-1:0]           ta_q;
  logic signed [SMP_W-1:0] d_q;
  logic signed [39:0]      prod_q;
  logic [30:0]             sq_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [EN_W-1:0]         en_q;
  logic signed [OUT_W-1:0] y_q;
  logic signed [OUT_W-1:0] e_q;
  logic signed [36:0]      m_q;
  logic [PW-1:0]           power_q;
  logic signed [52:0]      p_q;
  logic signed [WGT_W-1:0] w_hold_q;
  logic signed [DWW-1:0]   dw_q;
  logic                    smp_q;

  // statistics
  logic [SUM_W-1:0]  sum_q;
  logic [CW-1:0]     count_q;
  logic [MSE_W-1:0]  least_q;
  logic              conv_q;
  logic [STEP_W-1:0] conv_at_q;
  logic [STEP_W-1:0] steps_q;
  logic [PEAK_W-1:0] peak_q;
  logic [MSE_W-1:0]  mse_q;

  // output register
  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] out_q;

  // combinational helpers
  logic                    accept;
  logic                    clr_filt;
  logic                    tap_we;
  logic                    w_we;
  logic                    last_tap;
  logic [AW-1:0]           ta_prev;
  logic [AW-1:0]           wp_next;
  logic [OW-1:0]           ord_c;
  logic [17:0]             mu_c;
  logic [ACC_W-1:0]        acc_mag;
  logic [ACC_W-1:0]        acc_rnd;
  logic signed [OUT_W-1:0] y_c;
  logic signed [18:0]      diff_c;
  logic signed [OUT_W-1:0] e_c;
  logic signed [18:0]      mu_s;
  logic signed [36:0]      m_c;
  logic signed [52:0]      p_c;
  logic [52:0]             p_mag;
  logic [52:0]             p_rnd;
  logic signed [DWW-1:0]   dw_c;
  logic signed [DWW-1:0]   dw_div;
  logic signed [DWW:0]     w_sum;
  logic signed [WGT_W-1:0] w_new;
  logic [35:0]             esq;
  logic [SUM_W:0]          sum_add;
  logic [OUT_W-1:0]        e_abs;
  logic [PEAK_W-1:0]       e_abs_sat;
  logic                    win_full;
  logic                    win_over;
  logic [MSE_W-1:0]        mse_c;
  logic                    div_start;
  logic [DIV_NW-1:0]       div_num;
  logic [PW-1:0]           div_den;
  logic                    div_done;
  logic [DIV_NW-1:0]       div_quot;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;

  assign clr_filt = (cfg_we_i && cfg_idx_i == REG_ORDER) ||
                    (accept && s_axis_tuser == OP_CLR_FILT);
  assign tap_we   = accept && s_axis_tuser == OP_SAMPLE;
  assign w_we     = (state_q == S_UPD_WR);

  assign tap_x = tap_rdv_q ? tap_rd_q : '0;
  assign w_x   = w_rdv_q ? w_rd_q : '0;

  // index bookkeeping over the circular delay line
  always_comb begin
    last_tap = (idx_q == AW'(order_q - OW'(1)));
    ta_prev  = (ta_q == '0) ? AW'(order_q - OW'(1)) : ta_q - AW'(1);
    wp_next  = ((OW'(wp_q) + OW'(1)) == order_q) ? '0 : wp_q + AW'(1);
  end

  // register write clamping
  always_comb begin
    if (cfg_wdata_i[5:0] == 6'd0) begin
      ord_c = OW'(1);
    end else if (32'(cfg_wdata_i[5:0]) > ORDER_MAX) begin
      ord_c = OW'(ORDER_MAX);
    end else begin
      ord_c = OW'(cfg_wdata_i[5:0]);
    end
    if (cfg_wdata_i[17:0] == 18'd0) begin
      mu_c = 18'd1;
    end else if (32'(cfg_wdata_i[17:0]) > STEP_MAX) begin
      mu_c = 18'(STEP_MAX);
    end else begin
      mu_c = cfg_wdata_i[17:0];
    end
  end

  // output rounding and error saturation
  always_comb begin
    acc_mag = acc_q[ACC_W-1] ? $unsigned(-acc_q) : $unsigned(acc_q);
    acc_rnd = (acc_mag + ACC_W'(1 << 19)) >> 20;
    if (!acc_q[ACC_W-1]) begin
      y_c = (acc_rnd > ACC_W'(OUT_MAX)) ? OUT_W'(OUT_MAX) : $signed(acc_rnd[OUT_W-1:0]);
    end else if (acc_rnd > ACC_W'(OUT_MAX + 1)) begin
      y_c = $signed(OUT_W'(-(OUT_MAX + 1)));
    end else begin
      y_c = -$signed(acc_rnd[OUT_W-1:0]);
    end
    diff_c = 19'(d_q) - 19'(y_q);
    if (diff_c > 19'sd131071) begin
      e_c = OUT_W'(OUT_MAX);
    end else if (diff_c < -19'sd131072) begin
      e_c = $signed(OUT_W'(-(OUT_MAX + 1)));
    end else begin
      e_c = diff_c[OUT_W-1:0];
    end
  end

  // step factor, per-tap product and weight increment
  always_comb begin
    mu_s = $signed({1'b0, mu_q});
    if (mode_q == MODE_SIGN) begin
      if (e_q > 0) begin
        m_c = 37'(mu_s);
      end else if (e_q < 0) begin
        m_c = -37'(mu_s);
      end else begin
        m_c = '0;
      end
    end else begin
      m_c = mu_s * e_q;
    end
    p_c   = m_q * tap_x;
    p_mag = p_q[52] ? $unsigned(-p_q) : $unsigned(p_q);
    if (mode_q == MODE_SIGN) begin
      p_rnd = (p_mag + 53'(1 << 10)) >> 11;
    end else begin
      p_rnd = (p_mag + 53'(1 << 25)) >> 26;
    end
    dw_c    = p_q[52] ? -$signed(DWW'(p_rnd)) : $signed(DWW'(p_rnd));
    dw_div  = p_q[52] ? -$signed(DWW'(div_quot)) : $signed(DWW'(div_quot));
    w_sum   = (DWW + 1)'(w_hold_q) + (DWW + 1)'(dw_q);
    if (w_sum > (DWW + 1)'(8388607)) begin
      w_new = 24'sh7FFFFF;
    end else if (w_sum < -(DWW + 1)'(8388608)) begin
      w_new = 24'sh800000;
    end else begin
      w_new = w_sum[WGT_W-1:0];
    end
  end

  // error statistics
  always_comb begin
    esq       = $unsigned(36'(e_q) * 36'(e_q));
    sum_add   = (SUM_W + 1)'(sum_q) + (SUM_W + 1)'(esq);
    e_abs     = e_q[OUT_W-1] ? $unsigned(-e_q) : $unsigned(e_q);
    e_abs_sat = (e_abs > OUT_W'(PEAK_MAX)) ? PEAK_W'(PEAK_MAX) : e_abs[PEAK_W-1:0];
    win_full  = 32'(count_q) >= 32'(order_q) * 2;
    win_over  = 32'(count_q) > 32'(order_q) * 10;
    mse_c     = (|div_quot[DIV_NW-1:MSE_W]) ? '1 : div_quot[MSE_W-1:0];
  end

  // shared divider: per-tap normalized update, then the mean squared error
  always_comb begin
    div_start = (state_q == S_UPD_DW && mode_q == MODE_NLMS) ||
                (state_q == S_STAT && win_full);
    if (state_q == S_STAT) begin
      div_num = DIV_NW'(sum_q);
      div_den = PW'(count_q);
    end else begin
      div_num = (DIV_NW'(p_mag) << 4) + DIV_NW'(power_q >> 1);
      div_den = power_q;
    end
  end

  alms_div #(
    .NW(DIV_NW),
    .DW(PW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // tap and weight memories, registered read
  always_ff @(posedge clk_i) begin
    if (tap_we) begin
      tap_mem[wp_q] <= $signed(s_axis_tdata[SMP_W-1:0]);
    end
    tap_rd_q <= tap_mem[ta_q];
    if (w_we) begin
      w_mem[idx_q] <= w_new;
    end
    w_rd_q <= w_mem[idx_q];
  end

  // control, statistics and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mode_q    <= MODE_NLMS;
      order_q   <= OW'(ORD_RST);
      mu_q      <= 18'd6554;
      eps_q     <= 32'd1074;
      thr_q     <= 32'd10737418;
      tap_vld_q <= '0;
      w_vld_q   <= '0;
      tap_rdv_q <= 1'b0;
      w_rdv_q   <= 1'b0;
      wp_q      <= '0;
      idx_q     <= '0;
      ta_q      <= '0;
      d_q       <= '0;
      prod_q    <= '0;
      sq_q      <= '0;
      acc_q     <= '0;
      en_q      <= '0;
      y_q       <= '0;
      e_q       <= '0;
      m_q       <= '0;
      power_q   <= '0;
      p_q       <= '0;
      w_hold_q  <= '0;
      dw_q      <= '0;
      smp_q     <= 1'b0;
      sum_q     <= '0;
      count_q   <= '0;
      least_q   <= '1;
      conv_q    <= 1'b0;
      conv_at_q <= '0;
      steps_q   <= '0;
      peak_q    <= '0;
      mse_q     <= '0;
      m_valid_q <= 1'b0;
      out_q     <= '0;
    end else begin
      tap_rdv_q <= tap_vld_q[ta_q];
      w_rdv_q   <= w_vld_q[idx_q];

      if (m_valid_q && m_axis_tready && state_q != S_FIN) begin
        m_valid_q <= 1'b0;
      end

      // register writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MODE:   mode_q  <= cfg_wdata_i[1:0];
          REG_ORDER:  order_q <= ord_c;
          REG_STEP:   mu_q    <= mu_c;
          REG_EPS:    eps_q   <= (cfg_wdata_i == '0) ? 32'd1 : cfg_wdata_i;
          REG_THRESH: thr_q   <= (cfg_wdata_i == '0) ? 32'd1 : cfg_wdata_i;
          default: ;
        endcase
      end

      // filter state and convergence statistics clear
      if (clr_filt) begin
        tap_vld_q <= '0;
        w_vld_q   <= '0;
        wp_q      <= '0;
        sum_q     <= '0;
        count_q   <= '0;
        least_q   <= '1;
        conv_q    <= 1'b0;
        conv_at_q <= '0;
        mse_q     <= '0;
      end

      if (tap_we) begin
        tap_vld_q[wp_q] <= 1'b1;
      end
      if (w_we) begin
        w_vld_q[idx_q] <= 1'b1;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            d_q   <= $signed(s_axis_tdata[2*SMP_W-1:SMP_W]);
            idx_q <= '0;
            ta_q  <= wp_q;
            acc_q <= '0;
            en_q  <= '0;
            y_q   <= '0;
            e_q   <= '0;
            smp_q <= (s_axis_tuser == OP_SAMPLE);
            if (s_axis_tuser == OP_SAMPLE) begin
              state_q <= S_MAC_RD;
            end else begin
              if (s_axis_tuser == OP_CLR_STATS) begin
                steps_q <= '0;
                peak_q  <= '0;
              end
              state_q <= S_FIN;
            end
          end
        end
        // dot product and tap energy, one tap per pass
        S_MAC_RD: state_q <= S_MAC_MUL;
        S_MAC_MUL: begin
          prod_q  <= w_x * tap_x;
          sq_q    <= 31'($unsigned(32'(tap_x * tap_x)));
          state_q <= S_MAC_ACC;
        end
        S_MAC_ACC: begin
          acc_q <= acc_q + ACC_W'(prod_q);
          en_q  <= en_q + EN_W'(sq_q);
          if (last_tap) begin
            state_q <= S_Y;
          end else begin
            idx_q   <= idx_q + AW'(1);
            ta_q    <= ta_prev;
            state_q <= S_MAC_RD;
          end
        end
        S_Y: begin
          y_q     <= y_c;
          state_q <= S_ERR;
        end
        S_ERR: begin
          e_q     <= e_c;
          state_q <= S_PREP;
        end
        // step factor, normalizer and error accumulation
        S_PREP: begin
          m_q     <= m_c;
          power_q <= PW'(eps_q) + PW'(en_q);
          sum_q   <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
          count_q <= count_q + CW'(1);
          if (e_abs_sat > peak_q) begin
            peak_q <= e_abs_sat;
          end
          idx_q   <= '0;
          ta_q    <= wp_q;
          state_q <= (mode_q == MODE_LMS || mode_q == MODE_NLMS || mode_q == MODE_SIGN)
                     ? S_UPD_RD : S_STAT;
        end
        // weight update, read-modify-write per tap
        S_UPD_RD: state_q <= S_UPD_MUL;
        S_UPD_MUL: begin
          p_q      <= p_c;
          w_hold_q <= w_x;
          state_q  <= S_UPD_DW;
        end
        S_UPD_DW: begin
          dw_q    <= dw_c;
          state_q <= (mode_q == MODE_NLMS) ? S_UPD_DIV : S_UPD_WR;
        end
        S_UPD_DIV: begin
          if (div_done) begin
            dw_q    <= dw_div;
            state_q <= S_UPD_WR;
          end
        end
        S_UPD_WR: begin
          if (last_tap) begin
            state_q <= S_STAT;
          end else begin
            idx_q   <= idx_q + AW'(1);
            ta_q    <= ta_prev;
            state_q <= S_UPD_RD;
          end
        end
        S_STAT: begin
          wp_q    <= wp_next;
          state_q <= win_full ? S_MSE_DIV : S_FIN;
        end
        // mean squared error, convergence latch and window halving
        S_MSE_DIV: begin
          if (div_done) begin
            mse_q <= mse_c;
            if (mse_c < thr_q && !conv_q) begin
              conv_q    <= 1'b1;
              conv_at_q <= steps_q;
            end
            if (mse_c < least_q) begin
              least_q <= mse_c;
            end
            if (win_over) begin
              sum_q   <= sum_q >> 1;
              count_q <= count_q >> 1;
            end
            state_q <= S_FIN;
          end
        end
        // hand the result to the output register
        S_FIN: begin
          if (!m_valid_q || m_axis_tready) begin
            if (smp_q) begin
              steps_q <= steps_q + STEP_W'(1);
            end
            out_q     <= {2'b00, peak_q, conv_at_q, conv_q, mse_q, e_q, y_q};
            m_valid_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/alms_chk.sv =====
// Port-level checks for the adaptive LMS FIR filter, bound to the top level.
// Depends on alms_pkg.
`default_nettype none

module alms_chk (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [alms_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  import alms_pkg::*;

  logic [OUT_W-1:0]  err;
  logic [OUT_W-1:0]  err_abs;
  logic              err_min;
  logic [PEAK_W-1:0] peak;
  logic              conv;
  logic [STEP_W-1:0] step;

  always_comb begin
    err     = m_axis_tdata[OFS_ERR +: OUT_W];
    err_abs = err[OUT_W-1] ? (~err + OUT_W'(1)) : err;
    err_min = (err == {1'b1, {(OUT_W-1){1'b0}}});
    peak    = m_axis_tdata[OFS_PEAK +: PEAK_W];
    conv    = m_axis_tdata[OFS_CONV];
    step    = m_axis_tdata[OFS_STEP +: STEP_W];
  end

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // one item at a time: input closes after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input open right after a transfer");

  // convergence step only reported once converged
  a_conv_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !conv |-> step == '0)
    else $error("converge step set without convergence");

  // peak error covers the reported error
  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !err_min |-> 32'(peak) >= 32'(err_abs))
    else $error("peak error below current error");

endmodule

bind adaptive_lms_fir_filter alms_chk u_alms_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
